/* sv/lgs_pkg.sv */
package lgs_pkg;

  localparam int DEFAULT_ROWS = 8;
  localparam int DEFAULT_COLS = 8;

  localparam int IDX_W  = 3;
  localparam int CELL_W = 8;

  localparam int QUEUE_DEPTH = 2;

  localparam int NB_W        = 4;
  localparam int KEEP_COUNT  = 2;
  localparam int BIRTH_COUNT = 3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic              is_step;
    logic              load_ok;
    logic [IDX_W-1:0]  row_index;
    logic [CELL_W-1:0] row_cells;
  } op_t;

endpackage

/* sv/lgs_front.sv */
module lgs_front
  import lgs_pkg::*;
#(
  parameter int ROWS = DEFAULT_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [IDX_W-1:0]  in_row_index,
  input  logic [CELL_W-1:0] in_row_cells,
  output logic              op_valid,
  output op_t               op,
  input  logic              op_pop
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  op_t           q_r [QUEUE_DEPTH];
  logic [QW-1:0] wptr_r;
  logic [QW-1:0] rptr_r;
  logic [QW:0]   cnt_r;
  op_t           in_op;
  logic          push;

  always_comb begin
    in_op.is_step   = (in_kind == KIND_STEP);
    in_op.load_ok   = (in_kind == KIND_LOAD) && (32'(in_row_index) < ROWS);
    in_op.row_index = in_row_index;
    in_op.row_cells = in_row_cells;
  end

  assign in_stall = (cnt_r == (QW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign op_valid = (cnt_r != '0);
  assign op       = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QW'(QUEUE_DEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (op_pop) begin
        rptr_r <= (rptr_r == QW'(QUEUE_DEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !op_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (op_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QW+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> op_valid)
    else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !op_pop |=> cnt_r == (QW+1)'($past(cnt_r) + 1'b1))
    else $error("queue count did not follow a push");
`endif

endmodule

/* sv/lgs_back.sv */
module lgs_back
  import lgs_pkg::*;
#(
  parameter int ROWS = DEFAULT_ROWS,
  parameter int COLS = DEFAULT_COLS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  input  op_t               op,
  output logic              op_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_row_index,
  output logic [CELL_W-1:0] out_row_cells,
  output logic              out_last_row
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_t;

  state_t            state_r;
  logic [RW-1:0]     rcnt_r;
  logic [COLS-1:0]   grid_r [ROWS];
  logic [COLS-1:0]   grid_nxt [ROWS];
  logic [COLS-1:0]   load_cells;
  logic [63:0]       load_wide;
  logic [63:0]       rep_wide;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CELL_W-1:0] out_cells_r;
  logic              out_last_r;
  logic              out_take;

  assign op_pop        = op_valid && (state_r == ST_IDLE);
  assign out_take      = !out_valid_r || !out_stall;
  assign load_wide     = 64'(op.row_cells);
  assign load_cells    = load_wide[COLS-1:0];
  assign rep_wide      = 64'(grid_r[rcnt_r]);
  assign out_valid     = out_valid_r;
  assign out_row_index = out_idx_r;
  assign out_row_cells = out_cells_r;
  assign out_last_row  = out_last_r;

  always_comb begin
    int up;
    int dn;
    int lf;
    int rt;
    logic [NB_W-1:0] nb;
    for (int r = 0; r < ROWS; r++) begin
      up = (r == 0) ? ROWS - 1 : r - 1;
      dn = (r == ROWS - 1) ? 0 : r + 1;
      for (int c = 0; c < COLS; c++) begin
        lf = (c == 0) ? COLS - 1 : c - 1;
        rt = (c == COLS - 1) ? 0 : c + 1;
        nb = NB_W'(grid_r[r][lf]) + NB_W'(grid_r[up][lf]) + NB_W'(grid_r[up][c])
           + NB_W'(grid_r[up][rt]) + NB_W'(grid_r[r][rt]) + NB_W'(grid_r[dn][rt])
           + NB_W'(grid_r[dn][c]) + NB_W'(grid_r[dn][lf]);
        grid_nxt[r][c] = (nb == NB_W'(BIRTH_COUNT))
                      || (grid_r[r][c] && (nb == NB_W'(KEEP_COUNT)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      out_cells_r <= '0;
      out_last_r  <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        case (r)
          0:       grid_r[r] <= COLS'(2);
          1:       grid_r[r] <= COLS'(4);
          2:       grid_r[r] <= COLS'(7);
          default: grid_r[r] <= '0;
        endcase
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
          if (op_pop) begin
            if (op.is_step) begin
              grid_r  <= grid_nxt;
              rcnt_r  <= '0;
              state_r <= ST_REPORT;
            end else if (op.load_ok) begin
              for (int r = 0; r < ROWS; r++) begin
                if (32'(op.row_index) == r) begin
                  grid_r[r] <= load_cells;
                end
              end
            end
          end
        end
        ST_REPORT: begin
          if (out_take) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= IDX_W'(rcnt_r);
            out_cells_r <= rep_wide[CELL_W-1:0];
            out_last_r  <= (32'(rcnt_r) == ROWS - 1);
            if (32'(rcnt_r) == ROWS - 1) begin
              rcnt_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              rcnt_r <= rcnt_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_idx_r == IDX_W'((ROWS - 1) % 8))
    else $error("last row flag on wrong row");
  a_rcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rcnt_r) < ROWS)
    else $error("report row counter out of range");
  a_step_report: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop && op.is_step |=> state_r == ST_REPORT && rcnt_r == '0)
    else $error("step did not start a report");
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> rcnt_r == '0)
    else $error("row counter not cleared after report");
`endif

endmodule

/* sv/life_grid_step.sv */
// Conway's Life on a ROWS by COLS torus, held in flip-flops; reset loads a
// glider into the top-left corner.
// Requests enter on the in_ channel. A load request (kind 0) overwrites one
// row and produces no response; a row index at or beyond ROWS is dropped.
// A step request (kind 1) advances every cell at once and then reports the
// new grid as ROWS row responses on the out_ channel, row 0 first, with
// out_last_row set on the final one.
// A two-entry request queue sits between the input handshake and the grid
// engine, so requests are taken while a report is still being sent.
// The engine applies a load as it pops it. A step first updates the grid and
// then registers the rows one after another into the output register; the
// engine pops no further request until the last row has been registered.
// out_stall holds the current response in the output register and pauses the
// report; once the queue is full, in_stall rises.
// A synchronous low rst_n empties the queue, drops any report in progress and
// restores the glider.
module life_grid_step
  import lgs_pkg::*;
#(
  parameter int ROWS = DEFAULT_ROWS,
  parameter int COLS = DEFAULT_COLS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [IDX_W-1:0]  in_row_index,
  input  logic [CELL_W-1:0] in_row_cells,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_row_index,
  output logic [CELL_W-1:0] out_row_cells,
  output logic              out_last_row
);

  logic op_valid;
  op_t  op;
  logic op_pop;

  lgs_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_row_index (in_row_index),
    .in_row_cells (in_row_cells),
    .op_valid     (op_valid),
    .op           (op),
    .op_pop       (op_pop)
  );

  lgs_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_valid      (op_valid),
    .op            (op),
    .op_pop        (op_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_row_cells (out_row_cells),
    .out_last_row  (out_last_row)
  );

endmodule

/* bench/life_grid_step_tb.sv */
module life_grid_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lgs_pkg::*;

  localparam int GRID_ROWS = DEFAULT_ROWS;
  localparam int GRID_COLS = DEFAULT_COLS;
  localparam logic [63:0] COL_MASK = {64{1'b1}} >> (64 - GRID_COLS);
  localparam int LONG_HOLD_AT = 80;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 220;

  typedef struct {
    logic              kind;
    logic [IDX_W-1:0]  row_index;
    logic [CELL_W-1:0] row_cells;
    bit                settle_first;
  } life_req_t;

  typedef struct {
    logic [IDX_W-1:0]  row_index;
    logic [CELL_W-1:0] row_cells;
    logic              last_row;
  } row_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = KIND_LOAD;
  logic [IDX_W-1:0]  in_row_index = '0;
  logic [CELL_W-1:0] in_row_cells = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_row_index;
  logic [CELL_W-1:0] out_row_cells;
  logic              out_last_row;

  logic [63:0] life_grid [GRID_ROWS];
  life_req_t   request_queue [$];
  row_report_t generation_rows [$];
  life_req_t   next_req;
  row_report_t got_row;
  int          mismatches = 0;
  int          items_queued = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          rows_taken = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  life_grid_step dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_row_index (in_row_index),
    .in_row_cells (in_row_cells),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row_index(out_row_index),
    .out_row_cells(out_row_cells),
    .out_last_row (out_last_row)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic note_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one accepted request to the grid and queues the rows it reports.
  function automatic void apply_request(logic kind, logic [IDX_W-1:0] idx,
                                        logic [CELL_W-1:0] cells);
    logic [63:0] next_grid [GRID_ROWS];
    row_report_t rpt;
    int up, dn, lf, rt, nb;
    if (kind == KIND_LOAD) begin
      if (int'(idx) < GRID_ROWS) life_grid[idx] = 64'(cells) & COL_MASK;
      return;
    end
    for (int r = 0; r < GRID_ROWS; r++) begin
      next_grid[r] = '0;
      up = (r + GRID_ROWS - 1) % GRID_ROWS;
      dn = (r + 1) % GRID_ROWS;
      for (int c = 0; c < GRID_COLS; c++) begin
        lf = (c + GRID_COLS - 1) % GRID_COLS;
        rt = (c + 1) % GRID_COLS;
        nb = life_grid[r][lf] + life_grid[up][lf] + life_grid[up][c] +
             life_grid[up][rt] + life_grid[r][rt] + life_grid[dn][rt] +
             life_grid[dn][c] + life_grid[dn][lf];
        if ((life_grid[r][c] && nb == KEEP_COUNT) || nb == BIRTH_COUNT)
          next_grid[r][c] = 1'b1;
      end
    end
    for (int r = 0; r < GRID_ROWS; r++) begin
      life_grid[r] = next_grid[r];
      rpt.row_index = IDX_W'(r % 8);
      rpt.row_cells = life_grid[r][CELL_W-1:0];
      rpt.last_row  = (r == GRID_ROWS - 1);
      generation_rows.push_back(rpt);
    end
  endfunction

  task automatic queue_load(int idx, int cells, bit settle = 1'b0);
    life_req_t req;
    req.kind         = KIND_LOAD;
    req.row_index    = IDX_W'(idx);
    req.row_cells    = CELL_W'(cells);
    req.settle_first = settle;
    request_queue.push_back(req);
    items_queued++;
  endtask

  task automatic queue_step();
    life_req_t req;
    req.kind         = KIND_STEP;
    req.row_index    = IDX_W'($urandom_range(0, 7));
    req.row_cells    = CELL_W'($urandom_range(0, 255));
    req.settle_first = 1'b0;
    request_queue.push_back(req);
    items_queued++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(in_kind, in_row_index, in_row_cells);
        send_gap = pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0 &&
                     !(request_queue[0].settle_first && generation_rows.size() != 0)) begin
          next_req = request_queue.pop_front();
          in_kind <= next_req.kind;
          in_row_index <= next_req.row_index;
          in_row_cells <= next_req.row_cells;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (generation_rows.size() == 0) begin
          note_mismatch($sformatf("unexpected row %0d cells %h", out_row_index,
                                  out_row_cells));
        end else begin
          got_row = generation_rows.pop_front();
          if (out_row_index !== got_row.row_index)
            note_mismatch($sformatf("row index %0d, expected %0d", out_row_index,
                                    got_row.row_index));
          if (out_row_cells !== got_row.row_cells)
            note_mismatch($sformatf("row %0d cells %h, expected %h", got_row.row_index,
                                    out_row_cells, got_row.row_cells));
          if (out_last_row !== got_row.last_row)
            note_mismatch($sformatf("row %0d last flag %b, expected %b",
                                    got_row.row_index, out_last_row, got_row.last_row));
        end
        rows_taken++;
        recv_gap = pick_gap();
      end
      if (!hold_done && rows_taken >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int n_loads;
    int n_steps;
    int cells;
    int style;
    for (int r = 0; r < GRID_ROWS; r++) life_grid[r] = '0;
    life_grid[0] = 64'h2;
    life_grid[1] = 64'h4;
    life_grid[2] = 64'h7;

    // The glider from reset, then a fully live grid, which dies out.
    queue_step();
    queue_step();
    for (int r = 0; r < 8; r++) queue_load(r, 8'hFF);
    queue_step();
    // A blinker that straddles the left and right edges.
    queue_load(3, 8'b1000_0011);
    queue_step();
    queue_step();
    // A vertical blinker across the top and bottom edges, loaded once the
    // previous report has fully drained.
    queue_load(3, 8'h00, 1'b1);
    queue_load(7, 8'h10);
    queue_load(0, 8'h10);
    queue_load(1, 8'h10);
    queue_step();
    queue_step();

    while (items_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        n_loads = $urandom_range(1, 4);
        for (int i = 0; i < n_loads; i++) begin
          style = $urandom_range(0, 9);
          if (style < 5) cells = $urandom & $urandom;
          else if (style < 8) cells = $urandom_range(0, 255);
          else if (style < 9) cells = 8'h00;
          else cells = 8'hFF;
          queue_load($urandom_range(0, 7), cells);
        end
        n_steps = $urandom_range(1, 3);
        for (int i = 0; i < n_steps; i++) queue_step();
      end else if ($urandom_range(0, 1) == 0) begin
        queue_step();
      end else begin
        queue_load($urandom_range(0, 7), $urandom_range(0, 255));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || in_valid || generation_rows.size() != 0)
      @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
